/* design/sjga_pkg.sv */
package sjga_pkg;

    // Fixed Shift-JIS range table size and derived widths
    localparam int TABLE_RANGES = 88;
    localparam int RID_W        = 7;
    localparam int IDX_W        = 14;
    localparam int CODE_W       = 16;
    localparam int ADDR_W       = 24;
    localparam int GSIZE_W      = 7;
    localparam int PROD_W       = IDX_W + GSIZE_W;
    localparam int SUM_W        = ADDR_W + 1;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam logic [CODE_W-1:0] SINGLE_BYTE_LIMIT = 16'h0100;
    localparam logic [ADDR_W-1:0] ADDR_MAX          = 24'hFF_FFFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_HALF_BYTES = 2'd0,
        REG_HALF_BASE  = 2'd1,
        REG_FULL_BYTES = 2'd2,
        REG_FULL_BASE  = 2'd3
    } t_reg_idx;

    typedef logic [CODE_W-1:0] t_span_arr [0:TABLE_RANGES-1];
    typedef logic [IDX_W-1:0]  t_cum_arr  [0:TABLE_RANGES-1];

    localparam t_span_arr SPAN_LO = '{
        16'h8140, 16'h8180, 16'h81b8, 16'h81c8, 16'h81da, 16'h81f0, 16'h81fc, 16'h824f,
        16'h8260, 16'h8281, 16'h829f, 16'h8340, 16'h8380, 16'h839f, 16'h83bf, 16'h8440,
        16'h8470, 16'h8480, 16'h849f, 16'h889f, 16'h8940, 16'h8980, 16'h8a40, 16'h8a80,
        16'h8b40, 16'h8b80, 16'h8c40, 16'h8c80, 16'h8d40, 16'h8d80, 16'h8e40, 16'h8e80,
        16'h8f40, 16'h8f80, 16'h9040, 16'h9080, 16'h9140, 16'h9180, 16'h9240, 16'h9280,
        16'h9340, 16'h9380, 16'h9440, 16'h9480, 16'h9540, 16'h9580, 16'h9640, 16'h9680,
        16'h9740, 16'h9780, 16'h9840, 16'h989f, 16'h9940, 16'h9980, 16'h9a40, 16'h9a80,
        16'h9b40, 16'h9b80, 16'h9c40, 16'h9c80, 16'h9d40, 16'h9d80, 16'h9e40, 16'h9e80,
        16'h9f40, 16'h9f80, 16'he040, 16'he080, 16'he140, 16'he180, 16'he240, 16'he280,
        16'he340, 16'he380, 16'he440, 16'he480, 16'he540, 16'he580, 16'he640, 16'he680,
        16'he740, 16'he780, 16'he840, 16'he880, 16'he940, 16'he980, 16'hea40, 16'hea80
    };

    localparam t_span_arr SPAN_HI = '{
        16'h817e, 16'h81ac, 16'h81bf, 16'h81ce, 16'h81e8, 16'h81f7, 16'h81fc, 16'h8258,
        16'h8279, 16'h829a, 16'h82f1, 16'h837e, 16'h8396, 16'h83b6, 16'h83d6, 16'h8460,
        16'h847e, 16'h8491, 16'h84be, 16'h88fc, 16'h897e, 16'h89fc, 16'h8a7e, 16'h8afc,
        16'h8b7e, 16'h8bfc, 16'h8c7e, 16'h8cfc, 16'h8d7e, 16'h8dfc, 16'h8e7e, 16'h8efc,
        16'h8f7e, 16'h8ffc, 16'h907e, 16'h90fc, 16'h917e, 16'h91fc, 16'h927e, 16'h92fc,
        16'h937e, 16'h93fc, 16'h947e, 16'h94fc, 16'h957e, 16'h95fc, 16'h967e, 16'h96fc,
        16'h977e, 16'h97fc, 16'h9872, 16'h98fc, 16'h997e, 16'h99fc, 16'h9a7e, 16'h9afc,
        16'h9b7e, 16'h9bfc, 16'h9c7e, 16'h9cfc, 16'h9d7e, 16'h9dfc, 16'h9e7e, 16'h9efc,
        16'h9f7e, 16'h9ffc, 16'he07e, 16'he0fc, 16'he17e, 16'he1fc, 16'he27e, 16'he2fc,
        16'he37e, 16'he3fc, 16'he47e, 16'he4fc, 16'he57e, 16'he5fc, 16'he67e, 16'he6fc,
        16'he77e, 16'he7fc, 16'he87e, 16'he8fc, 16'he97e, 16'he9fc, 16'hea7e, 16'heaa4
    };

    // Glyph count of all ranges before each range, built at elaboration
    function automatic t_cum_arr cum_table();
        t_cum_arr               c;
        logic [IDX_W-1:0]       acc;
        acc = '0;
        for (int i = 0; i < TABLE_RANGES; i++) begin
            c[i] = acc;
            acc  = acc + IDX_W'(SPAN_HI[i] - SPAN_LO[i] + 16'd1);
        end
        return c;
    endfunction

    localparam t_cum_arr SPAN_CUM = cum_table();

    // Word passed from range match to index build
    typedef struct packed {
        logic                single;
        logic                found;
        logic [RID_W-1:0]    rid;
        logic [CODE_W-1:0]   code;
    } t_range_word;

    // Word passed from index build to scaling
    typedef struct packed {
        logic                single;
        logic                found;
        logic [IDX_W-1:0]    operand;
    } t_index_word;

endpackage

/* design/sjga_range_match.sv */
module sjga_range_match #(
    parameter int NUM_RANGES = 88
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sjga_pkg::CODE_W-1:0] i_char_code,
    output logic                        o_valid,
    input  logic                        i_ready,
    output sjga_pkg::t_range_word       o_data
);
    import sjga_pkg::*;

    logic                    r_s1_valid;
    logic [TABLE_RANGES-1:0] r_s1_hit;
    logic [CODE_W-1:0]       r_s1_code;
    logic                    r_s1_single;
    logic [TABLE_RANGES-1:0] n_hit;
    logic                    n_single;
    logic                    s1_ready;

    logic                    r_s2_valid;
    t_range_word             r_s2_data;
    logic [RID_W-1:0]        n_rid;
    logic                    s2_ready;

    // Compare the code against every enabled range in parallel
    always_comb begin
        n_single = (i_char_code < SINGLE_BYTE_LIMIT);
        for (int i = 0; i < TABLE_RANGES; i++) begin
            n_hit[i] = (i < NUM_RANGES) && !n_single &&
                       (i_char_code >= SPAN_LO[i]) && (i_char_code <= SPAN_HI[i]);
        end
    end

    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    // Hold the compare results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
        if (s1_ready && i_valid) begin
            r_s1_hit    <= n_hit;
            r_s1_code   <= i_char_code;
            r_s1_single <= n_single;
        end
    end

    // Encode the one-hot hit into a range number
    always_comb begin
        n_rid = '0;
        for (int i = 0; i < TABLE_RANGES; i++) begin
            if (r_s1_hit[i]) begin
                n_rid = n_rid | RID_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_data.single <= r_s1_single;
            r_s2_data.found  <= r_s1_single || (|r_s1_hit);
            r_s2_data.rid    <= n_rid;
            r_s2_data.code   <= r_s1_code;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_data  = r_s2_data;

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $onehot0(r_s1_hit))
        else $error("code matched more than one range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_single |-> (r_s1_hit == '0))
        else $error("single-byte code matched a double-byte range");
`endif

endmodule

/* design/sjga_index.sv */
module sjga_index (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sjga_pkg::t_range_word i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sjga_pkg::t_index_word o_data
);
    import sjga_pkg::*;

    logic             r_valid;
    t_index_word      r_data;
    logic [IDX_W-1:0] n_operand;
    logic [IDX_W-1:0] glyph_idx;

    // Glyphs before the range plus distance into it
    assign glyph_idx = SPAN_CUM[i_data.rid] +
                       IDX_W'(i_data.code - SPAN_LO[i_data.rid]);

    // Single-byte codes scale the code itself
    assign n_operand = i_data.single ? IDX_W'(i_data.code[7:0]) : glyph_idx;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data.single  <= i_data.single;
            r_data.found   <= i_data.found;
            r_data.operand <= n_operand;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* design/sjga_scale.sv */
module sjga_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  sjga_pkg::t_index_word        i_data,
    input  logic [sjga_pkg::GSIZE_W-1:0] i_half_bytes,
    input  logic [sjga_pkg::ADDR_W-1:0]  i_half_base,
    input  logic [sjga_pkg::GSIZE_W-1:0] i_full_bytes,
    input  logic [sjga_pkg::ADDR_W-1:0]  i_full_base,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sjga_pkg::ADDR_W-1:0]  o_glyph_address,
    output logic                         o_found,
    output logic                         o_overflow
);
    import sjga_pkg::*;

    logic               r_mul_valid;
    logic [PROD_W-1:0]  r_mul_prod;
    logic               r_mul_single;
    logic               r_mul_found;
    logic [GSIZE_W-1:0] gsize;
    logic [PROD_W-1:0]  n_prod;
    logic               mul_ready;

    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_out_addr;
    logic               r_out_found;
    logic               r_out_ovf;
    logic [ADDR_W-1:0]  base;
    logic [SUM_W-1:0]   n_sum;
    logic [ADDR_W-1:0]  n_addr;
    logic               n_ovf;

    // Multiply the glyph index by the glyph size
    assign gsize  = i_data.single ? i_half_bytes : i_full_bytes;
    assign n_prod = PROD_W'(i_data.operand) * PROD_W'(gsize);

    assign o_ready   = !r_mul_valid || mul_ready;
    assign mul_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (o_ready) begin
            r_mul_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_mul_prod   <= n_prod;
            r_mul_single <= i_data.single;
            r_mul_found  <= i_data.found;
        end
    end

    // Add the base, saturate at 24 bits, zero a miss
    assign base  = r_mul_single ? i_half_base : i_full_base;
    assign n_sum = SUM_W'(r_mul_prod) + SUM_W'(base);

    always_comb begin
        if (!r_mul_found) begin
            n_addr = '0;
            n_ovf  = 1'b0;
        end else if (n_sum[ADDR_W]) begin
            n_addr = ADDR_MAX;
            n_ovf  = 1'b1;
        end else begin
            n_addr = n_sum[ADDR_W-1:0];
            n_ovf  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (mul_ready) begin
            r_out_valid <= r_mul_valid;
        end
        if (mul_ready && r_mul_valid) begin
            r_out_addr  <= n_addr;
            r_out_found <= r_mul_found;
            r_out_ovf   <= n_ovf;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_glyph_address = r_out_addr;
    assign o_found         = r_out_found;
    assign o_overflow      = r_out_ovf;

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> (r_out_addr == '0) && !r_out_ovf)
        else $error("missed code gave a non-zero word");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ovf |-> (r_out_addr == ADDR_MAX) && r_out_found)
        else $error("overflow without saturated address");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_valid && r_mul_single |-> r_mul_found)
        else $error("single-byte code marked not found");
`endif

endmodule

/* design/sjis_glyph_address.sv */
// Channel   | Handshake          | Payload
// ----------+--------------------+----------------------------------------------
// input     | i_valid / o_ready  | i_char_code[15:0]
// output    | o_valid / i_ready  | o_glyph_address[23:0], o_found, o_overflow
// config    | psel/penable/pwrite| paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One word enters per cycle while the output is not stalled, and each result
// passes five register stages: range compare, range encode, index build,
// glyph-size multiply and base add with saturation.
// Reset clears every stage's valid bit and loads the register defaults.
// A stall at the output backs up stage by stage; empty stages keep filling.
module sjis_glyph_address #(
    parameter int NUM_RANGES = 88
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [15:0]                   i_char_code,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [23:0]                   o_glyph_address,
    output logic                          o_found,
    output logic                          o_overflow,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sjga_pkg::PADDR_W-1:0]  paddr,
    input  logic [sjga_pkg::PDATA_W-1:0]  pwdata,
    output logic [sjga_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import sjga_pkg::*;

    logic [GSIZE_W-1:0] r_half_bytes;
    logic [ADDR_W-1:0]  r_half_base;
    logic [GSIZE_W-1:0] r_full_bytes;
    logic [ADDR_W-1:0]  r_full_base;
    t_reg_idx           reg_sel;
    logic               cfg_wr;

    logic               rng_valid;
    logic               rng_ready;
    t_range_word        rng_data;
    logic               idx_valid;
    logic               idx_ready;
    t_index_word        idx_data;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bytes <= GSIZE_W'(16);
            r_half_base  <= '0;
            r_full_bytes <= GSIZE_W'(32);
            r_full_base  <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_HALF_BYTES: r_half_bytes <= pwdata[GSIZE_W-1:0];
                REG_HALF_BASE:  r_half_base  <= pwdata[ADDR_W-1:0];
                REG_FULL_BYTES: r_full_bytes <= pwdata[GSIZE_W-1:0];
                REG_FULL_BASE:  r_full_base  <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        case (reg_sel)
            REG_HALF_BYTES: prdata = PDATA_W'(r_half_bytes);
            REG_HALF_BASE:  prdata = PDATA_W'(r_half_base);
            REG_FULL_BYTES: prdata = PDATA_W'(r_full_bytes);
            REG_FULL_BASE:  prdata = PDATA_W'(r_full_base);
            default:        prdata = '0;
        endcase
    end

    sjga_range_match #(
        .NUM_RANGES (NUM_RANGES)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .o_valid     (rng_valid),
        .i_ready     (rng_ready),
        .o_data      (rng_data)
    );

    sjga_index u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rng_valid),
        .o_ready (rng_ready),
        .i_data  (rng_data),
        .o_valid (idx_valid),
        .i_ready (idx_ready),
        .o_data  (idx_data)
    );

    sjga_scale u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (idx_valid),
        .o_ready         (idx_ready),
        .i_data          (idx_data),
        .i_half_bytes    (r_half_bytes),
        .i_half_base     (r_half_base),
        .i_full_bytes    (r_full_bytes),
        .i_full_base     (r_full_base),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_glyph_address (o_glyph_address),
        .o_found         (o_found),
        .o_overflow      (o_overflow)
    );

endmodule

/* verif/tb_sjis_glyph_address.sv */
module tb_sjis_glyph_address;
    import sjga_pkg::*;

    localparam int N_SPANS         = 88;
    localparam int N_SETTINGS      = 8;
    localparam int WORDS_PER_PHASE = 65;
    localparam int N_PROBES        = 23;
    localparam int HOLD_CYCLES     = 60;
    localparam int SETTLE_CYCLES   = 8;

    typedef struct packed {
        logic [23:0] addr;
        logic        found;
        logic        ovf;
    } t_glyph;

    typedef struct packed {
        logic [15:0] code;
        logic        known;
        logic [23:0] addr;
        logic        found;
        logic        ovf;
    } t_probe;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [15:0]          i_char_code = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [23:0]          o_glyph_address;
    logic                 o_found;
    logic                 o_overflow;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Shift-JIS code ranges, each word {first, last}, inclusive and sorted
    logic [31:0] sjis_spans [0:N_SPANS-1] = '{
        32'h8140817e, 32'h818081ac, 32'h81b881bf, 32'h81c881ce,
        32'h81da81e8, 32'h81f081f7, 32'h81fc81fc, 32'h824f8258,
        32'h82608279, 32'h8281829a, 32'h829f82f1, 32'h8340837e,
        32'h83808396, 32'h839f83b6, 32'h83bf83d6, 32'h84408460,
        32'h8470847e, 32'h84808491, 32'h849f84be, 32'h889f88fc,
        32'h8940897e, 32'h898089fc, 32'h8a408a7e, 32'h8a808afc,
        32'h8b408b7e, 32'h8b808bfc, 32'h8c408c7e, 32'h8c808cfc,
        32'h8d408d7e, 32'h8d808dfc, 32'h8e408e7e, 32'h8e808efc,
        32'h8f408f7e, 32'h8f808ffc, 32'h9040907e, 32'h908090fc,
        32'h9140917e, 32'h918091fc, 32'h9240927e, 32'h928092fc,
        32'h9340937e, 32'h938093fc, 32'h9440947e, 32'h948094fc,
        32'h9540957e, 32'h958095fc, 32'h9640967e, 32'h968096fc,
        32'h9740977e, 32'h978097fc, 32'h98409872, 32'h989f98fc,
        32'h9940997e, 32'h998099fc, 32'h9a409a7e, 32'h9a809afc,
        32'h9b409b7e, 32'h9b809bfc, 32'h9c409c7e, 32'h9c809cfc,
        32'h9d409d7e, 32'h9d809dfc, 32'h9e409e7e, 32'h9e809efc,
        32'h9f409f7e, 32'h9f809ffc, 32'he040e07e, 32'he080e0fc,
        32'he140e17e, 32'he180e1fc, 32'he240e27e, 32'he280e2fc,
        32'he340e37e, 32'he380e3fc, 32'he440e47e, 32'he480e4fc,
        32'he540e57e, 32'he580e5fc, 32'he640e67e, 32'he680e6fc,
        32'he740e77e, 32'he780e7fc, 32'he840e87e, 32'he880e8fc,
        32'he940e97e, 32'he980e9fc, 32'hea40ea7e, 32'hea80eaa4
    };

    // Directed codes under reset settings; known rows carry their result
    t_probe probes [0:N_PROBES-1] = '{
        '{16'h0000, 1'b1, 24'h000000, 1'b1, 1'b0},
        '{16'h00ff, 1'b1, 24'h000ff0, 1'b1, 1'b0},
        '{16'h0080, 1'b0, 24'h000000, 1'b0, 1'b0},
        '{16'h0100, 1'b1, 24'h000000, 1'b0, 1'b0},
        '{16'h5555, 1'b1, 24'h000000, 1'b0, 1'b0},
        '{16'h813f, 1'b1, 24'h000000, 1'b0, 1'b0},
        '{16'h8140, 1'b1, 24'h000000, 1'b1, 1'b0},
        '{16'h817e, 1'b1, 24'h0007c0, 1'b1, 1'b0},
        '{16'h817f, 1'b1, 24'h000000, 1'b0, 1'b0},
        '{16'h8180, 1'b1, 24'h0007e0, 1'b1, 1'b0},
        '{16'h81ac, 1'b0, 24'h000000, 1'b0, 1'b0},
        '{16'h81fc, 1'b0, 24'h000000, 1'b0, 1'b0},
        '{16'h84bf, 1'b1, 24'h000000, 1'b0, 1'b0},
        '{16'h889f, 1'b0, 24'h000000, 1'b0, 1'b0},
        '{16'h88fc, 1'b0, 24'h000000, 1'b0, 1'b0},
        '{16'h9872, 1'b0, 24'h000000, 1'b0, 1'b0},
        '{16'h989f, 1'b0, 24'h000000, 1'b0, 1'b0},
        '{16'haaaa, 1'b1, 24'h000000, 1'b0, 1'b0},
        '{16'he040, 1'b0, 24'h000000, 1'b0, 1'b0},
        '{16'hea80, 1'b0, 24'h000000, 1'b0, 1'b0},
        '{16'heaa4, 1'b0, 24'h000000, 1'b0, 1'b0},
        '{16'heaa5, 1'b1, 24'h000000, 1'b0, 1'b0},
        '{16'hffff, 1'b1, 24'h000000, 1'b0, 1'b0}
    };

    logic [15:0] edge_codes [0:3] = '{16'h0000, 16'h00ff, 16'h8140, 16'heaa4};

    // Mirror of the register file
    logic [6:0]  half_bytes_q = 7'd16;
    logic [23:0] half_base_q  = '0;
    logic [6:0]  full_bytes_q = 7'd32;
    logic [23:0] full_base_q  = '0;

    t_glyph      glyph_q [$];
    t_glyph      want;
    logic [31:0] settings [0:N_SETTINGS-1][0:3];
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_hits = 0;
    int          n_misses = 0;
    int          n_saturated = 0;

    sjis_glyph_address dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Work out the flash address of one code under the mirrored registers
    function automatic t_glyph lookup_glyph(input logic [15:0] code);
        longint unsigned ordinal;
        longint unsigned byte_addr;
        logic [15:0]     lo;
        logic [15:0]     hi;
        t_glyph          r;
        bit              hit;
        r         = '0;
        ordinal   = 0;
        byte_addr = 0;
        hit       = 1'b0;
        if (code < SINGLE_BYTE_LIMIT) begin
            hit       = 1'b1;
            byte_addr = 64'(code) * 64'(half_bytes_q) + 64'(half_base_q);
        end else begin
            // Sum the glyphs of earlier ranges until the code's own range
            for (int k = 0; k < N_SPANS; k++) begin
                lo = sjis_spans[k][31:16];
                hi = sjis_spans[k][15:0];
                if (code < lo) break;
                if (code <= hi) begin
                    hit     = 1'b1;
                    ordinal = ordinal + 64'(code - lo);
                    break;
                end
                ordinal = ordinal + 64'(hi - lo) + 1;
            end
            if (hit) byte_addr = ordinal * 64'(full_bytes_q) + 64'(full_base_q);
        end
        if (hit) begin
            r.found = 1'b1;
            if (byte_addr > 64'(ADDR_MAX)) begin
                r.addr = ADDR_MAX;
                r.ovf  = 1'b1;
            end else begin
                r.addr = byte_addr[23:0];
            end
        end
        return r;
    endfunction

    // Mostly codes inside the ranges, some single-byte, some edges, some noise
    function automatic logic [15:0] pick_code();
        logic [31:0] s;
        s = sjis_spans[$urandom_range(N_SPANS - 1, 0)];
        case ($urandom_range(9, 0))
            0, 1: return 16'($urandom_range(255, 0));
            7: begin
                case ($urandom_range(3, 0))
                    0: return s[31:16] - 16'd1;
                    1: return s[31:16];
                    2: return s[15:0];
                    default: return s[15:0] + 16'd1;
                endcase
            end
            8, 9: return 16'($urandom);
            default: return 16'($urandom_range(s[15:0], s[31:16]));
        endcase
    endfunction

    // Offer one word, hold it until taken, then file its expected result
    task automatic send_word(input logic [15:0] code, input t_glyph res);
        @(negedge i_clk);
        if (!quiet && $urandom_range(4, 0) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= code;
        do @(posedge i_clk); while (!o_ready);
        glyph_q.push_back(res);
        n_sent++;
    endtask

    // Drop valid and wait for every result to come back
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (glyph_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_HALF_BYTES: half_bytes_q = val[6:0];
            REG_HALF_BASE:  half_base_q  = val[23:0];
            REG_FULL_BYTES: full_bytes_q = val[6:0];
            REG_FULL_BASE:  full_base_q  = val[23:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: random stalls, one long hold-off on request, none at the end
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(5, 0) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(9, 1)) @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (glyph_q.size() == 0) begin
                $error("result word with nothing expected: address %h", o_glyph_address);
                n_errors++;
            end else begin
                want = glyph_q.pop_front();
                n_checked++;
                if (want.found) n_hits++;
                else n_misses++;
                if (want.ovf) n_saturated++;
                if (o_glyph_address !== want.addr) begin
                    $error("glyph_address: expected %h, got %h", want.addr, o_glyph_address);
                    n_errors++;
                end
                if (o_found !== want.found) begin
                    $error("found: expected %b, got %b", want.found, o_found);
                    n_errors++;
                end
                if (o_overflow !== want.ovf) begin
                    $error("overflow: expected %b, got %b", want.ovf, o_overflow);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        t_glyph      res;
        logic [15:0] code;

        // Register settings: extremes, zero size, oversized writes, random
        settings[0] = '{32'd1, 32'd0, 32'd1, 32'd0};
        settings[1] = '{32'd64, 32'h00ff_ffff, 32'd64, 32'h00ff_ffff};
        settings[2] = '{32'd0, $urandom & 32'h00ff_ffff, 32'd0, $urandom & 32'h00ff_ffff};
        settings[3] = '{32'hffff_ffff, 32'hffff_ffff, 32'({$urandom, 7'h05}), $urandom};
        settings[4] = '{32'd64, 32'h00ff_ffff - $urandom_range(16383, 0),
                        32'd64, 32'h00ff_ffff - $urandom_range(600000, 0)};
        settings[5] = '{$urandom_range(64, 1), $urandom & 32'h00ff_ffff,
                        $urandom_range(64, 1), $urandom & 32'h00ff_ffff};
        settings[6] = '{$urandom_range(64, 1), $urandom & 32'h00ff_ffff,
                        $urandom_range(64, 1), $urandom & 32'h00ff_ffff};
        settings[7] = '{32'd16, 32'd0, 32'd32, 32'd0};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed codes under the reset settings
        for (int r = 0; r < N_PROBES; r++) begin
            if (probes[r].known) res = '{probes[r].addr, probes[r].found, probes[r].ovf};
            else res = lookup_glyph(probes[r].code);
            send_word(probes[r].code, res);
        end
        drain();

        // Random codes under each setting; the last phase runs without idling
        for (int p = 0; p < N_SETTINGS; p++) begin
            for (int r = 0; r < 4; r++) write_reg(t_reg_idx'(r), settings[p][r]);
            quiet = (p == N_SETTINGS - 1);
            for (int w = 0; w < WORDS_PER_PHASE; w++) begin
                code = (w < 4) ? edge_codes[w] : pick_code();
                if (p == 0 && w == 20) hold_req = 1'b1;
                send_word(code, lookup_glyph(code));
            end
            drain();
        end

        $display("Sent %0d codes over %0d register settings, one %0d-cycle output hold-off.",
                 n_sent, N_SETTINGS + 1, HOLD_CYCLES);
        $display("Checked %0d results: %0d found, %0d not found, %0d saturated.",
                 n_checked, n_hits, n_misses, n_saturated);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
